// ----- sv/impulse_collision_resolver_unit_macros.svh -----
// assertion helpers shared by the rtl
`ifndef IMPULSE_COLLISION_RESOLVER_UNIT_MACROS_SVH
`define IMPULSE_COLLISION_RESOLVER_UNIT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define ICR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define ICR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/icr_pkg.sv -----
package icr_pkg;

    // divider geometry: quotient bits, divisor bits, dividend bits
    localparam int QUO_W      = 37;
    localparam int DEN_W      = 32;
    localparam int NUM_W      = QUO_W + DEN_W;
    localparam int DIV_STAGES = QUO_W;

    // divider lanes
    localparam int LANES   = 4;
    localparam int LANE_DA = 0;
    localparam int LANE_DB = 1;
    localparam int LANE_GA = 2;
    localparam int LANE_GB = 3;

    // body flag bits
    localparam int FLAG_A_BODY = 0;
    localparam int FLAG_A_KIN  = 1;
    localparam int FLAG_B_BODY = 2;
    localparam int FLAG_B_KIN  = 3;

    // 1.0 in q2.14
    localparam int ONE_Q14 = 16384;

    // width of the back-end products and sums
    localparam int PROD_W = 56;
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(8192);
    localparam logic signed [PROD_W-1:0] SAT_HI   = PROD_W'(2147483647);
    localparam logic signed [PROD_W-1:0] SAT_LO   = ~SAT_HI;

    typedef enum logic [1:0] {
        OUT_FIXED     = 2'd0,
        OUT_SEPARATED = 2'd1,
        OUT_IMPULSE   = 2'd2
    } t_outcome;

    typedef logic [NUM_W-1:0] t_num;
    typedef logic [QUO_W-1:0] t_quo;

    // per-contact data carried alongside the divider
    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [31:0] vax;
        logic signed [31:0] vay;
        logic signed [31:0] vbx;
        logic signed [31:0] vby;
        t_outcome           outcome;
    } t_ctx;

    // floor((x + 8192) / 16384)
    function automatic logic signed [PROD_W-1:0] rnd14(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] y;
        y = x + RND_HALF;
        return y >>> 14;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [31:0] r;
        if (x > SAT_HI) begin
            r = SAT_HI[31:0];
        end else if (x < SAT_LO) begin
            r = SAT_LO[31:0];
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/icr_front.sv -----
module icr_front
    import icr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic [30:0]        i_penetration,
    input  logic signed [31:0] i_vel_a_x,
    input  logic signed [31:0] i_vel_a_y,
    input  logic signed [31:0] i_vel_b_x,
    input  logic signed [31:0] i_vel_b_y,
    input  logic [30:0]        i_mass_a,
    input  logic [30:0]        i_mass_b,
    input  logic [14:0]        i_restitution_a,
    input  logic [14:0]        i_restitution_b,
    input  logic [3:0]         i_body_flags,
    output logic               o_valid,
    output t_ctx               o_ctx,
    output t_num [LANES-1:0]   o_num,
    output logic [DEN_W-1:0]   o_den
);

    // stage 1: flags, masking, mass sum, restitution, velocity differences
    logic               n_pres_a, n_pres_b, n_mov_a, n_mov_b;
    t_ctx               n_s1_ctx;
    logic [30:0]        n_s1_ma, n_s1_mb;
    logic [14:0]        n_e;
    logic [15:0]        n_s1_k;
    logic [DEN_W-1:0]   n_s1_s;
    logic signed [32:0] n_s1_dvx, n_s1_dvy;

    logic               r_s1_vld;
    t_ctx               r_s1_ctx;
    logic [30:0]        r_s1_pen, r_s1_mb;
    logic [DEN_W-1:0]   r_s1_s;
    logic               r_s1_mov_a, r_s1_mov_b;
    logic [15:0]        r_s1_k;
    logic signed [32:0] r_s1_dvx, r_s1_dvy;

    always_comb begin
        n_pres_a = i_body_flags[FLAG_A_BODY];
        n_pres_b = i_body_flags[FLAG_B_BODY];
        n_mov_a  = n_pres_a && !i_body_flags[FLAG_A_KIN];
        n_mov_b  = n_pres_b && !i_body_flags[FLAG_B_KIN];
        n_s1_ctx.nx      = i_normal_x;
        n_s1_ctx.ny      = i_normal_y;
        n_s1_ctx.vax     = n_pres_a ? i_vel_a_x : '0;
        n_s1_ctx.vay     = n_pres_a ? i_vel_a_y : '0;
        n_s1_ctx.vbx     = n_pres_b ? i_vel_b_x : '0;
        n_s1_ctx.vby     = n_pres_b ? i_vel_b_y : '0;
        n_s1_ctx.outcome = OUT_FIXED;
        n_s1_ma = (i_mass_a == '0) ? 31'd1 : i_mass_a;
        n_s1_mb = (i_mass_b == '0) ? 31'd1 : i_mass_b;
        n_s1_s  = {1'b0, n_s1_ma} + {1'b0, n_s1_mb};
        if (n_pres_a && n_pres_b) begin
            n_e = (i_restitution_a < i_restitution_b) ? i_restitution_a : i_restitution_b;
        end else if (n_pres_a) begin
            n_e = i_restitution_a;
        end else if (n_pres_b) begin
            n_e = i_restitution_b;
        end else begin
            n_e = 15'(ONE_Q14);
        end
        n_s1_k   = 16'(ONE_Q14) + 16'(n_e);
        n_s1_dvx = 33'(n_s1_ctx.vax) - 33'(n_s1_ctx.vbx);
        n_s1_dvy = 33'(n_s1_ctx.vay) - 33'(n_s1_ctx.vby);
    end

    // stage 2: weights and normal products
    logic [DEN_W-1:0]   n_s2_wa, n_s2_wb;
    logic signed [48:0] n_s2_px, n_s2_py;

    logic               r_s2_vld;
    t_ctx               r_s2_ctx;
    logic [30:0]        r_s2_pen;
    logic [DEN_W-1:0]   r_s2_s, r_s2_wa, r_s2_wb;
    logic               r_s2_mov;
    logic [15:0]        r_s2_k;
    logic signed [48:0] r_s2_px, r_s2_py;

    always_comb begin
        n_s2_wa = r_s1_mov_a ? (r_s1_mov_b ? {1'b0, r_s1_mb} : r_s1_s) : '0;
        n_s2_wb = r_s1_mov_b ? (r_s1_mov_a ? r_s1_s - {1'b0, r_s1_mb} : r_s1_s) : '0;
        n_s2_px = 49'(r_s1_dvx) * 49'(r_s1_ctx.nx);
        n_s2_py = 49'(r_s1_dvy) * 49'(r_s1_ctx.ny);
    end

    // stage 3: approach speed along the normal
    logic               r_s3_vld;
    t_ctx               r_s3_ctx;
    logic [30:0]        r_s3_pen;
    logic [DEN_W-1:0]   r_s3_s, r_s3_wa, r_s3_wb;
    logic               r_s3_mov;
    logic [15:0]        r_s3_k;
    logic signed [49:0] r_s3_vn;

    // stage 4: outcome and rounded approach speed
    logic signed [50:0] n_s4_t;
    logic [34:0]        n_s4_vq;
    t_ctx               n_s4_ctx;

    logic               r_s4_vld;
    t_ctx               r_s4_ctx;
    logic [30:0]        r_s4_pen;
    logic [DEN_W-1:0]   r_s4_s, r_s4_wa, r_s4_wb;
    logic [15:0]        r_s4_k;
    logic [34:0]        r_s4_vq;

    always_comb begin
        n_s4_t   = -51'(r_s3_vn) + 51'sd8192;
        // separating contacts get no impulse: a zero speed gives zero gains
        n_s4_vq  = (r_s3_vn > 0) ? '0 : n_s4_t[48:14];
        n_s4_ctx = r_s3_ctx;
        if (!r_s3_mov) begin
            n_s4_ctx.outcome = OUT_FIXED;
        end else if (r_s3_vn > 0) begin
            n_s4_ctx.outcome = OUT_SEPARATED;
        end else begin
            n_s4_ctx.outcome = OUT_IMPULSE;
        end
    end

    // stage 5: speed times (1 + e)
    logic               r_s5_vld;
    t_ctx               r_s5_ctx;
    logic [30:0]        r_s5_pen;
    logic [DEN_W-1:0]   r_s5_s, r_s5_wa, r_s5_wb;
    logic [50:0]        r_s5_impr;

    // stage 6: rounded impulse
    logic [51:0]        n_s6_sum;
    logic               r_s6_vld;
    t_ctx               r_s6_ctx;
    logic [30:0]        r_s6_pen;
    logic [DEN_W-1:0]   r_s6_s, r_s6_wa, r_s6_wb;
    logic [QUO_W-1:0]   r_s6_imp;

    assign n_s6_sum = 52'(r_s5_impr) + 52'd8192;

    // stage 7: partial products of the dividends
    logic               r_s7_vld;
    t_ctx               r_s7_ctx;
    logic [DEN_W-1:0]   r_s7_s;
    logic [62:0]        r_s7_npa, r_s7_npb;
    logic [47:0]        r_s7_ila, r_s7_ilb;
    logic [52:0]        r_s7_iha, r_s7_ihb;

    // stage 8: full dividends
    t_num [LANES-1:0]   n_s8_num;
    logic               r_s8_vld;
    t_ctx               r_s8_ctx;
    logic [DEN_W-1:0]   r_s8_s;
    t_num [LANES-1:0]   r_s8_num;

    always_comb begin
        n_s8_num[LANE_DA] = NUM_W'(r_s7_npa);
        n_s8_num[LANE_DB] = NUM_W'(r_s7_npb);
        n_s8_num[LANE_GA] = NUM_W'({r_s7_iha, 16'b0}) + NUM_W'(r_s7_ila);
        n_s8_num[LANE_GB] = NUM_W'({r_s7_ihb, 16'b0}) + NUM_W'(r_s7_ilb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
            r_s8_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
            r_s7_vld <= r_s6_vld;
            r_s8_vld <= r_s7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_ctx   <= n_s1_ctx;
            r_s1_pen   <= i_penetration;
            r_s1_mb    <= n_s1_mb;
            r_s1_s     <= n_s1_s;
            r_s1_mov_a <= n_mov_a;
            r_s1_mov_b <= n_mov_b;
            r_s1_k     <= n_s1_k;
            r_s1_dvx   <= n_s1_dvx;
            r_s1_dvy   <= n_s1_dvy;

            r_s2_ctx <= r_s1_ctx;
            r_s2_pen <= r_s1_pen;
            r_s2_s   <= r_s1_s;
            r_s2_wa  <= n_s2_wa;
            r_s2_wb  <= n_s2_wb;
            r_s2_mov <= r_s1_mov_a || r_s1_mov_b;
            r_s2_k   <= r_s1_k;
            r_s2_px  <= n_s2_px;
            r_s2_py  <= n_s2_py;

            r_s3_ctx <= r_s2_ctx;
            r_s3_pen <= r_s2_pen;
            r_s3_s   <= r_s2_s;
            r_s3_wa  <= r_s2_wa;
            r_s3_wb  <= r_s2_wb;
            r_s3_mov <= r_s2_mov;
            r_s3_k   <= r_s2_k;
            r_s3_vn  <= 50'(r_s2_px) + 50'(r_s2_py);

            r_s4_ctx <= n_s4_ctx;
            r_s4_pen <= r_s3_pen;
            r_s4_s   <= r_s3_s;
            r_s4_wa  <= r_s3_wa;
            r_s4_wb  <= r_s3_wb;
            r_s4_k   <= r_s3_k;
            r_s4_vq  <= n_s4_vq;

            r_s5_ctx  <= r_s4_ctx;
            r_s5_pen  <= r_s4_pen;
            r_s5_s    <= r_s4_s;
            r_s5_wa   <= r_s4_wa;
            r_s5_wb   <= r_s4_wb;
            r_s5_impr <= 51'(r_s4_vq) * 51'(r_s4_k);

            r_s6_ctx <= r_s5_ctx;
            r_s6_pen <= r_s5_pen;
            r_s6_s   <= r_s5_s;
            r_s6_wa  <= r_s5_wa;
            r_s6_wb  <= r_s5_wb;
            r_s6_imp <= n_s6_sum[50:14];

            r_s7_ctx <= r_s6_ctx;
            r_s7_s   <= r_s6_s;
            r_s7_npa <= 63'(r_s6_pen) * 63'(r_s6_wa);
            r_s7_npb <= 63'(r_s6_pen) * 63'(r_s6_wb);
            r_s7_ila <= 48'(r_s6_imp[15:0]) * 48'(r_s6_wa);
            r_s7_ilb <= 48'(r_s6_imp[15:0]) * 48'(r_s6_wb);
            r_s7_iha <= 53'(r_s6_imp[QUO_W-1:16]) * 53'(r_s6_wa);
            r_s7_ihb <= 53'(r_s6_imp[QUO_W-1:16]) * 53'(r_s6_wb);

            r_s8_ctx <= r_s7_ctx;
            r_s8_s   <= r_s7_s;
            r_s8_num <= n_s8_num;
        end
    end

    assign o_valid = r_s8_vld;
    assign o_ctx   = r_s8_ctx;
    assign o_num   = r_s8_num;
    assign o_den   = r_s8_s;

endmodule

// ----- sv/icr_div.sv -----
module icr_div
    import icr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  t_num [LANES-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_quo [LANES-1:0] o_quo
);

    // restoring division, one quotient bit per stage, four lanes sharing a divisor
    // the bits word shifts dividend bits out at the top and quotient bits in below
    logic [DEN_W-1:0] r_den  [DIV_STAGES];
    logic [DEN_W-1:0] r_rem  [DIV_STAGES][LANES];
    logic [QUO_W-1:0] r_bits [DIV_STAGES][LANES];

    for (genvar gs = 0; gs < DIV_STAGES; gs++) begin : g_stage
        logic [DEN_W-1:0] den_in;
        logic [DEN_W-1:0] rem_in  [LANES];
        logic [QUO_W-1:0] bits_in [LANES];
        logic [DEN_W-1:0] n_rem   [LANES];
        logic [QUO_W-1:0] n_bits  [LANES];

        if (gs == 0) begin : g_first
            assign den_in = i_den;
            for (genvar gl = 0; gl < LANES; gl++) begin : g_ln
                assign rem_in[gl]  = i_num[gl][NUM_W-1:QUO_W];
                assign bits_in[gl] = i_num[gl][QUO_W-1:0];
            end
        end else begin : g_rest
            assign den_in = r_den[gs-1];
            for (genvar gl = 0; gl < LANES; gl++) begin : g_ln
                assign rem_in[gl]  = r_rem[gs-1][gl];
                assign bits_in[gl] = r_bits[gs-1][gl];
            end
        end

        always_comb begin
            logic [DEN_W:0] trial;
            logic           ge;
            for (int ln = 0; ln < LANES; ln++) begin
                trial      = {rem_in[ln], bits_in[ln][QUO_W-1]};
                ge         = (trial >= {1'b0, den_in});
                n_rem[ln]  = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
                n_bits[ln] = {bits_in[ln][QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[gs] <= den_in;
                for (int ln = 0; ln < LANES; ln++) begin
                    r_rem[gs][ln]  <= n_rem[ln];
                    r_bits[gs][ln] <= n_bits[ln];
                end
            end
        end
    end

    always_comb begin
        for (int ln = 0; ln < LANES; ln++) begin
            o_quo[ln] = r_bits[DIV_STAGES-1][ln];
        end
    end

endmodule

// ----- sv/icr_back.sv -----
module icr_back
    import icr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_ctx               i_ctx,
    input  t_quo [LANES-1:0]   i_quo,
    output logic               o_valid,
    output logic signed [31:0] o_shift_a_x,
    output logic signed [31:0] o_shift_a_y,
    output logic signed [31:0] o_shift_b_x,
    output logic signed [31:0] o_shift_b_y,
    output logic signed [31:0] o_new_vel_a_x,
    output logic signed [31:0] o_new_vel_a_y,
    output logic signed [31:0] o_new_vel_b_x,
    output logic signed [31:0] o_new_vel_b_y,
    output t_outcome           o_outcome
);

    localparam int NPROD = 2 * LANES;

    // product order: shift a x/y, shift b x/y, gain a x/y, gain b x/y
    logic signed [PROD_W-1:0] n_p [NPROD];
    logic signed [PROD_W-1:0] r_p [NPROD];
    logic signed [PROD_W-1:0] r_r [NPROD];
    t_ctx                     r_b1_ctx, r_b2_ctx;
    logic                     r_b1_vld, r_b2_vld, r_b3_vld;
    logic signed [31:0]       r_out [NPROD];
    t_outcome                 r_outcome;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_p[2*i]   = PROD_W'(i_ctx.nx) * PROD_W'($signed({1'b0, i_quo[i]}));
            n_p[2*i+1] = PROD_W'(i_ctx.ny) * PROD_W'($signed({1'b0, i_quo[i]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            r_b3_vld <= 1'b0;
        end else if (i_en) begin
            r_b1_vld <= i_valid;
            r_b2_vld <= r_b1_vld;
            r_b3_vld <= r_b2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1_ctx <= i_ctx;
            r_b2_ctx <= r_b1_ctx;
            r_outcome <= r_b2_ctx.outcome;
            for (int i = 0; i < NPROD; i++) begin
                r_p[i] <= n_p[i];
                // body b moves against the normal
                if (i == 2 || i == 3 || i == 6 || i == 7) begin
                    r_r[i] <= rnd14(-r_p[i]);
                end else begin
                    r_r[i] <= rnd14(r_p[i]);
                end
            end
            for (int i = 0; i < LANES; i++) begin
                r_out[i] <= sat32(r_r[i]);
            end
            r_out[4] <= sat32(PROD_W'(r_b2_ctx.vax) + r_r[4]);
            r_out[5] <= sat32(PROD_W'(r_b2_ctx.vay) + r_r[5]);
            r_out[6] <= sat32(PROD_W'(r_b2_ctx.vbx) + r_r[6]);
            r_out[7] <= sat32(PROD_W'(r_b2_ctx.vby) + r_r[7]);
        end
    end

    assign o_valid       = r_b3_vld;
    assign o_shift_a_x   = r_out[0];
    assign o_shift_a_y   = r_out[1];
    assign o_shift_b_x   = r_out[2];
    assign o_shift_b_y   = r_out[3];
    assign o_new_vel_a_x = r_out[4];
    assign o_new_vel_a_y = r_out[5];
    assign o_new_vel_b_x = r_out[6];
    assign o_new_vel_b_y = r_out[7];
    assign o_outcome     = r_outcome;

endmodule

// ----- sv/impulse_collision_resolver_unit.sv -----
// pipeline: 8 front-end stages, 37 divider stages, 3 back-end stages
// throughput: one transaction per cycle while o_stall is low, set by the fully pipelined divider
// all stages advance together; a held result holds the whole pipe
// reset: synchronous active-low i_rst_n clears every valid bit, the pipe comes up empty
`include "impulse_collision_resolver_unit_macros.svh"

module impulse_collision_resolver_unit
    import icr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // contact side
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic [30:0]        i_penetration,
    input  logic signed [31:0] i_vel_a_x,
    input  logic signed [31:0] i_vel_a_y,
    input  logic signed [31:0] i_vel_b_x,
    input  logic signed [31:0] i_vel_b_y,
    input  logic [30:0]        i_mass_a,
    input  logic [30:0]        i_mass_b,
    input  logic [14:0]        i_restitution_a,
    input  logic [14:0]        i_restitution_b,
    input  logic [3:0]         i_body_flags,
    // response side
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_shift_a_x,
    output logic signed [31:0] o_shift_a_y,
    output logic signed [31:0] o_shift_b_x,
    output logic signed [31:0] o_shift_b_y,
    output logic signed [31:0] o_new_vel_a_x,
    output logic signed [31:0] o_new_vel_a_y,
    output logic signed [31:0] o_new_vel_b_x,
    output logic signed [31:0] o_new_vel_b_y,
    output logic [1:0]         o_outcome
);

    // the pipe moves unless a finished result is being held downstream
    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // front end: inverse-mass weights, approach speed, impulse, dividends
    logic             w_front_vld;
    t_ctx             w_front_ctx;
    t_num [LANES-1:0] w_num;
    logic [DEN_W-1:0] w_den;

    icr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_valid         (i_valid),
        .i_normal_x      (i_normal_x),
        .i_normal_y      (i_normal_y),
        .i_penetration   (i_penetration),
        .i_vel_a_x       (i_vel_a_x),
        .i_vel_a_y       (i_vel_a_y),
        .i_vel_b_x       (i_vel_b_x),
        .i_vel_b_y       (i_vel_b_y),
        .i_mass_a        (i_mass_a),
        .i_mass_b        (i_mass_b),
        .i_restitution_a (i_restitution_a),
        .i_restitution_b (i_restitution_b),
        .i_body_flags    (i_body_flags),
        .o_valid         (w_front_vld),
        .o_ctx           (w_front_ctx),
        .o_num           (w_num),
        .o_den           (w_den)
    );

    // divider: floor(x * w / (ma + mb)) for both shifts and both gains
    t_quo [LANES-1:0] w_quo;

    icr_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_num),
        .i_den (w_den),
        .o_quo (w_quo)
    );

    // normal, velocities and outcome ride alongside the divider
    logic [DIV_STAGES-1:0] r_dly_vld;
    t_ctx                  r_dly_ctx [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_vld <= '0;
        end else if (w_en) begin
            r_dly_vld <= {r_dly_vld[DIV_STAGES-2:0], w_front_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly_ctx[0] <= w_front_ctx;
            for (int i = 1; i < DIV_STAGES; i++) begin
                r_dly_ctx[i] <= r_dly_ctx[i-1];
            end
        end
    end

    // back end: project onto the normal, round, add, saturate
    t_outcome w_outcome;

    icr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (r_dly_vld[DIV_STAGES-1]),
        .i_ctx         (r_dly_ctx[DIV_STAGES-1]),
        .i_quo         (w_quo),
        .o_valid       (o_valid),
        .o_shift_a_x   (o_shift_a_x),
        .o_shift_a_y   (o_shift_a_y),
        .o_shift_b_x   (o_shift_b_x),
        .o_shift_b_y   (o_shift_b_y),
        .o_new_vel_a_x (o_new_vel_a_x),
        .o_new_vel_a_y (o_new_vel_a_y),
        .o_new_vel_b_x (o_new_vel_b_x),
        .o_new_vel_b_y (o_new_vel_b_y),
        .o_outcome     (w_outcome)
    );

    assign o_outcome = w_outcome;

    // immovable pairs are never pushed apart
    `ICR_ASSERT_IMP(a_fixed_no_shift, o_valid && w_outcome == OUT_FIXED,
        o_shift_a_x == '0 && o_shift_a_y == '0 && o_shift_b_x == '0 && o_shift_b_y == '0,
        "shift on an immovable pair")

    // a held result must hold the contact side too
    `ICR_ASSERT_IMP(a_hold_back, o_valid && i_stall, o_stall, "pipe advanced under a held result")

    // nothing in flight is lost or duplicated while the pipe is held
    `ICR_ASSERT_NEXT(a_hold_keeps_flight, !w_en, $stable(r_dly_vld),
        "in-flight valids moved while held")

endmodule
